### hw/rtl/assert_macros.svh
// Assertion helpers, sampled on the block clock and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Check that a cause in one cycle brings an effect in the same cycle.
`define ASSERT_IMPLY(label, cause, effect, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cause) |-> (effect)) else $error(msg);

// Check that a cause in one cycle brings an effect in the next cycle.
`define ASSERT_NEXT(label, cause, effect, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cause) |=> (effect)) else $error(msg);

`endif

### hw/rtl/h2r_pkg.sv
package h2r_pkg;

    localparam int HUE_W    = 12;
    localparam int LEVEL_W  = 8;
    localparam int FACTOR_W = 10;
    localparam int NUM_W    = 18;

    localparam logic [HUE_W-1:0]    FULL_TURN   = 12'd3600;
    localparam logic [HUE_W-1:0]    SECTOR_SPAN = 12'd600;
    localparam logic [FACTOR_W-1:0] SPAN_FACTOR = 10'd600;

    // num / 600 == (num >> 3) / 75; 1/75 as 55925 / 2^22, exact for num <= 153000
    localparam logic [15:0] DIV75_RECIP = 16'd55925;
    localparam int          DIV75_SHIFT = 22;
    localparam int          DIV75_PROD_W = 31;

    typedef logic [2:0] t_sector;

    localparam t_sector SECTOR_RED_UP    = 3'd0;
    localparam t_sector SECTOR_GREEN_IN  = 3'd1;
    localparam t_sector SECTOR_GREEN_UP  = 3'd2;
    localparam t_sector SECTOR_BLUE_IN   = 3'd3;
    localparam t_sector SECTOR_BLUE_UP   = 3'd4;
    localparam t_sector SECTOR_RED_IN    = 3'd5;

    typedef struct packed {
        t_sector             sector;
        logic [FACTOR_W-1:0] factor;
    } t_sector_info;

endpackage

### hw/rtl/hsv_to_rgb_converter.sv
// HSV to RGB converter. Accepts one beat per clock unless stalled (hue in tenths
// of a degree in tdata[11:0], saturation in [19:12], value in [27:20]) and returns
// 8-bit red, green and blue levels, one result beat per input beat, in order. The
// five register stages are: hue wrap and value*saturation product, divide by 255 and
// sector split, chroma times sector offset, divide by 600 by reciprocal multiply, and
// the output register that routes chroma and the secondary level to the channels. Each
// stage holds its beat under back-pressure and fills empty slots, so a stall on the
// output drops or repeats nothing; unstalled, throughput is one beat per cycle.
`include "assert_macros.svh"

module hsv_to_rgb_converter
    import h2r_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [11:0] hue_tenths, [19:12] saturation_frac, [27:20] value_frac, [31:28] zero
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] red_level, [15:8] green_level, [23:16] blue_level
    output logic [23:0] m_axis_tdata
);

    logic [4:0] r_vld;
    logic [4:0] w_adv;

    logic [HUE_W-1:0]   w_hue_in;
    logic [LEVEL_W-1:0] w_sat_in;
    logic [LEVEL_W-1:0] w_val_in;

    // stage 0
    logic [HUE_W-1:0] r_hue0, n_hue0;
    logic [15:0]      r_prod0, n_prod0;
    // stage 1
    logic [16:0]         w_c_sum;
    t_sector_info        w_info;
    logic [LEVEL_W-1:0]  r_c1, n_c1;
    t_sector             r_sec1;
    logic [FACTOR_W-1:0] r_fac1;
    // stage 2
    logic [NUM_W-1:0]   r_num2, n_num2;
    logic [LEVEL_W-1:0] r_c2;
    t_sector            r_sec2;
    // stage 3
    logic [DIV75_PROD_W-1:0] w_div_prod;
    logic [LEVEL_W-1:0]      r_x3;
    logic [LEVEL_W-1:0]      r_c3;
    t_sector                 r_sec3;
    // stage 4 (output)
    logic [23:0] r_rgb4, n_rgb4;

    assign w_hue_in = s_axis_tdata[11:0];
    assign w_sat_in = s_axis_tdata[19:12];
    assign w_val_in = s_axis_tdata[27:20];

    // a stage may load when it is empty or its beat moves on
    assign w_adv[4] = !r_vld[4] || m_axis_tready;
    assign w_adv[3] = !r_vld[3] || w_adv[4];
    assign w_adv[2] = !r_vld[2] || w_adv[3];
    assign w_adv[1] = !r_vld[1] || w_adv[2];
    assign w_adv[0] = !r_vld[0] || w_adv[1];

    assign s_axis_tready = w_adv[0];
    assign m_axis_tvalid = r_vld[4];
    assign m_axis_tdata  = r_rgb4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) r_vld[0] <= s_axis_tvalid;
            if (w_adv[1]) r_vld[1] <= r_vld[0];
            if (w_adv[2]) r_vld[2] <= r_vld[1];
            if (w_adv[3]) r_vld[3] <= r_vld[2];
            if (w_adv[4]) r_vld[4] <= r_vld[3];
        end
    end

    // stage 0: wrap a full turn back to sector 0, form value * saturation
    always_comb begin
        n_hue0  = (w_hue_in >= FULL_TURN) ? (w_hue_in - FULL_TURN) : w_hue_in;
        n_prod0 = 16'(w_val_in) * 16'(w_sat_in);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_hue0  <= n_hue0;
            r_prod0 <= n_prod0;
        end
    end

    // stage 1: chroma = prod / 255, exact for products of two 8-bit levels
    h2r_sector u_sector (
        .i_hue  (r_hue0),
        .o_info (w_info)
    );

    always_comb begin
        w_c_sum = {1'b0, r_prod0} + 17'd1 + {9'b0, r_prod0[15:8]};
        n_c1    = w_c_sum[15:8];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r_c1   <= n_c1;
            r_sec1 <= w_info.sector;
            r_fac1 <= w_info.factor;
        end
    end

    // stage 2: chroma times the sector offset
    assign n_num2 = NUM_W'(r_c1) * NUM_W'(r_fac1);

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r_num2 <= n_num2;
            r_c2   <= r_c1;
            r_sec2 <= r_sec1;
        end
    end

    // stage 3: divide by 600 as (num >> 3) / 75 through the reciprocal
    assign w_div_prod = DIV75_PROD_W'(r_num2[NUM_W-1:3]) * DIV75_PROD_W'(DIV75_RECIP);

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            r_x3   <= w_div_prod[DIV75_SHIFT+LEVEL_W-1:DIV75_SHIFT];
            r_c3   <= r_c2;
            r_sec3 <= r_sec2;
        end
    end

    // stage 4: route chroma and secondary level to the channels
    always_comb begin
        unique case (r_sec3)
            SECTOR_RED_UP:   n_rgb4 = {8'd0, r_x3, r_c3};
            SECTOR_GREEN_IN: n_rgb4 = {8'd0, r_c3, r_x3};
            SECTOR_GREEN_UP: n_rgb4 = {r_x3, r_c3, 8'd0};
            SECTOR_BLUE_IN:  n_rgb4 = {r_c3, r_x3, 8'd0};
            SECTOR_BLUE_UP:  n_rgb4 = {r_c3, 8'd0, r_x3};
            default:         n_rgb4 = {r_x3, 8'd0, r_c3};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            r_rgb4 <= n_rgb4;
        end
    end

    `ASSERT_IMPLY(a_empty_head_ready, !r_vld[0], s_axis_tready,
        "input stage empty but not ready")
    `ASSERT_IMPLY(a_full_stall, (&r_vld) && !m_axis_tready, !s_axis_tready,
        "full pipeline under back-pressure still takes input")
    `ASSERT_IMPLY(a_secondary_le_chroma, r_vld[3], r_x3 <= r_c3,
        "secondary level exceeds chroma")
    `ASSERT_NEXT(a_sector_range, r_vld[1], r_sec2 <= SECTOR_RED_IN || !r_vld[2],
        "sector code out of range")

endmodule

### hw/rtl/h2r_sector.sv
module h2r_sector
    import h2r_pkg::*;
(
    input  logic [HUE_W-1:0] i_hue,
    output t_sector_info     o_info
);

    logic [2:0]          w_count;
    logic [HUE_W-1:0]    w_base;
    logic [HUE_W-1:0]    w_offs_full;
    logic [FACTOR_W-1:0] w_offs;

    // count sector boundaries below the hue; hue is already wrapped below a full turn
    always_comb begin
        w_count = {2'b00, (i_hue >= 12'd600)}  + {2'b00, (i_hue >= 12'd1200)}
                + {2'b00, (i_hue >= 12'd1800)} + {2'b00, (i_hue >= 12'd2400)}
                + {2'b00, (i_hue >= 12'd3000)};
        w_base      = 12'(SECTOR_SPAN * {9'b0, w_count});
        w_offs_full = i_hue - w_base;
        w_offs      = w_offs_full[FACTOR_W-1:0];

        o_info.sector = w_count;
        // odd sectors fall, even sectors rise
        o_info.factor = w_count[0] ? (SPAN_FACTOR - w_offs) : w_offs;
    end

endmodule
